>>> design/rtks_pkg.sv
// shared types and constants for the row top-k smallest selector
package rtks_pkg;

    localparam int VALUE_W     = 32;
    localparam int COL_FIELD_W = 16;
    localparam int K_CFG_W     = 7;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic [K_CFG_W-1:0]        K_RESET   = 7'd16;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COL_FIELD_W-1:0]    column;
        logic                      last_in_row;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [COL_FIELD_W-1:0]    column_out;
        logic                      valid_res;
        logic                      last_result;
    } out_word_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // per-cell control, decoded at the top level for each cell index
    typedef struct packed {
        logic insert;     // an input word is taken this cycle
        logic emit;       // the chain shifts toward cell 0
        logic full;       // store holds k entries
        logic at_last;    // this cell is the last one the insert may touch
        logic upto_last;  // this cell index is at or below that one
        logic drop;       // this cell index is at or beyond k
    } cell_ctrl_t;

endpackage

>>> design/rtks_cell.sv
// one slot of the sorted insertion chain
module rtks_cell #(
    parameter int COL_W = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rtks_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [rtks_pkg::VALUE_W-1:0]  ins_value,
    input  logic [COL_W-1:0]                     ins_column,
    input  logic signed [rtks_pkg::VALUE_W-1:0]  prev_value,
    input  logic [COL_W-1:0]                     prev_column,
    input  logic                                 prev_valid,
    input  logic                                 prev_gt,
    input  logic signed [rtks_pkg::VALUE_W-1:0]  next_value,
    input  logic [COL_W-1:0]                     next_column,
    input  logic                                 next_valid,
    output logic signed [rtks_pkg::VALUE_W-1:0]  value,
    output logic [COL_W-1:0]                     column,
    output logic                                 valid,
    output logic                                 gt
);

    logic signed [rtks_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [COL_W-1:0]                    column_reg, column_next;
    logic                                valid_reg, valid_next;

    // held entry is worse than the incoming word
    assign gt = value_reg > ins_value;

    always_comb begin
        value_next  = value_reg;
        column_next = column_reg;
        valid_next  = valid_reg;
        if (ctrl.emit) begin
            value_next  = next_value;
            column_next = next_column;
            valid_next  = next_valid;
        end else if (ctrl.insert) begin
            if (ctrl.drop) begin
                value_next  = rtks_pkg::VALUE_MAX;
                column_next = '0;
                valid_next  = 1'b0;
            end else if (ctrl.upto_last) begin
                if (prev_gt) begin
                    value_next  = prev_value;
                    column_next = prev_column;
                    valid_next  = prev_valid;
                end else if (gt || (ctrl.at_last && !ctrl.full)) begin
                    value_next  = ins_value;
                    column_next = ins_column;
                    valid_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg  <= rtks_pkg::VALUE_MAX;
            column_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            value_reg  <= value_next;
            column_reg <= column_next;
            valid_reg  <= valid_next;
        end
    end

    assign value  = value_reg;
    assign column = column_reg;
    assign valid  = valid_reg;

endmodule

>>> design/row_top_k_smallest_selector.sv
// top level: keeps the k smallest words of a row in a chain of cells and emits them sorted
// a word is absorbed in the cycle it is accepted; s_ready is high while loading,
// so a row streams in at one word per cycle.
// after the word marked last in row, the first result is shown the next cycle and the k results
// leave cell 0 one per cycle as m_ready allows; s_ready returns after the k-th result.
// reset (synchronous, active low) sets every cell to max value, column 0, invalid, fill 0, k 16;
// the emit shifts clear the chain, so there is no clearing pass.
module row_top_k_smallest_selector #(
    parameter int K_MAX       = 64,
    parameter int COLUMN_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rtks_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rtks_pkg::out_word_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rtks_pkg::K_CFG_W-1:0]    cfg_data
);

    localparam int COL_W = (COLUMN_BITS < rtks_pkg::COL_FIELD_W) ? COLUMN_BITS
                                                                 : rtks_pkg::COL_FIELD_W;
    localparam int KW = $clog2(K_MAX + 1);
    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CW = (KW > rtks_pkg::K_CFG_W) ? KW : rtks_pkg::K_CFG_W;

    rtks_pkg::state_t state_reg, state_next;
    logic [rtks_pkg::K_CFG_W-1:0] k_count_reg, k_count_next;
    logic [KW-1:0]                fill_reg, fill_next;
    logic [IW-1:0]                emit_cnt_reg, emit_cnt_next;

    logic [CW-1:0] k_ext;
    logic [KW-1:0] k_eff;
    logic [KW-1:0] fill_eff;
    logic [KW-1:0] last_idx;
    logic          full;
    logic          in_take;
    logic          out_take;
    logic          last_out;

    logic signed [rtks_pkg::VALUE_W-1:0] c_value [K_MAX];
    logic [COL_W-1:0]                    c_column [K_MAX];
    logic                                c_valid [K_MAX];
    logic                                c_gt [K_MAX];
    rtks_pkg::cell_ctrl_t                c_ctrl [K_MAX];
    logic [COL_W-1:0]                    ins_column;

    assign cfg_ready = 1'b1;

    // out-of-range k: zero reads as one, above K_MAX saturates
    assign k_ext = CW'(k_count_reg);
    always_comb begin
        if (k_ext == '0) begin
            k_eff = KW'(1);
        end else if (k_ext > CW'(K_MAX)) begin
            k_eff = KW'(K_MAX);
        end else begin
            k_eff = KW'(k_ext);
        end
    end

    // k lowered mid-row cuts the store back to k
    assign fill_eff = (fill_reg > k_eff) ? k_eff : fill_reg;
    assign full     = (fill_eff == k_eff);
    assign last_idx = full ? (k_eff - KW'(1)) : fill_eff;

    assign in_take    = s_valid && s_ready;
    assign out_take   = m_valid && m_ready;
    assign last_out   = (KW'(emit_cnt_reg) == (k_eff - KW'(1)));
    assign ins_column = s_data.column[COL_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rtks_pkg::ST_LOAD: begin
                if (in_take && s_data.last_in_row) begin
                    state_next = rtks_pkg::ST_EMIT;
                end
            end
            rtks_pkg::ST_EMIT: begin
                if (out_take && last_out) begin
                    state_next = rtks_pkg::ST_LOAD;
                end
            end
            default: state_next = rtks_pkg::ST_LOAD;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            rtks_pkg::ST_LOAD: s_ready = 1'b1;
            rtks_pkg::ST_EMIT: m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        k_count_next  = k_count_reg;
        fill_next     = fill_reg;
        emit_cnt_next = emit_cnt_reg;
        if (cfg_valid && cfg_ready) begin
            k_count_next = cfg_data;
        end
        if (in_take) begin
            fill_next     = fill_eff + KW'(!full);
            emit_cnt_next = '0;
        end
        if (out_take) begin
            emit_cnt_next = emit_cnt_reg + IW'(1);
            if (last_out) begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rtks_pkg::ST_LOAD;
            k_count_reg  <= rtks_pkg::K_RESET;
            fill_reg     <= '0;
            emit_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            k_count_reg  <= k_count_next;
            fill_reg     <= fill_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < K_MAX; gi++) begin : g_cell
            logic signed [rtks_pkg::VALUE_W-1:0] p_value, n_value;
            logic [COL_W-1:0]                    p_column, n_column;
            logic                                p_valid, n_valid, p_gt;

            assign c_ctrl[gi].insert    = in_take;
            assign c_ctrl[gi].emit      = out_take;
            assign c_ctrl[gi].full      = full;
            assign c_ctrl[gi].at_last   = (KW'(gi) == last_idx);
            assign c_ctrl[gi].upto_last = (KW'(gi) <= last_idx);
            assign c_ctrl[gi].drop      = (KW'(gi) >= k_eff);

            if (gi == 0) begin : g_head
                assign p_value  = rtks_pkg::VALUE_MAX;
                assign p_column = '0;
                assign p_valid  = 1'b0;
                assign p_gt     = 1'b0;
            end else begin : g_body
                assign p_value  = c_value[gi-1];
                assign p_column = c_column[gi-1];
                assign p_valid  = c_valid[gi-1];
                assign p_gt     = c_gt[gi-1];
            end

            if (gi == K_MAX - 1) begin : g_tail
                assign n_value  = rtks_pkg::VALUE_MAX;
                assign n_column = '0;
                assign n_valid  = 1'b0;
            end else begin : g_inner
                assign n_value  = c_value[gi+1];
                assign n_column = c_column[gi+1];
                assign n_valid  = c_valid[gi+1];
            end

            rtks_cell #(
                .COL_W(COL_W)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (c_ctrl[gi]),
                .ins_value   (s_data.value),
                .ins_column  (ins_column),
                .prev_value  (p_value),
                .prev_column (p_column),
                .prev_valid  (p_valid),
                .prev_gt     (p_gt),
                .next_value  (n_value),
                .next_column (n_column),
                .next_valid  (n_valid),
                .value       (c_value[gi]),
                .column      (c_column[gi]),
                .valid       (c_valid[gi]),
                .gt          (c_gt[gi])
            );
        end
    endgenerate

    // empty cells already hold max value and column zero
    assign m_data.value_out   = c_value[0];
    assign m_data.column_out  = rtks_pkg::COL_FIELD_W'(c_column[0]);
    assign m_data.valid_res   = c_valid[0];
    assign m_data.last_result = last_out;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result side active together");

    a_row_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && s_data.last_in_row) |=> m_valid)
        else $error("row end did not start emission");

    a_emit_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_take && last_out) |=> (s_ready && fill_reg == '0))
        else $error("store not released after final result");

    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (KW'(emit_cnt_reg) < k_eff))
        else $error("emit counter past k");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= KW'(K_MAX))
        else $error("fill count past chain length");

endmodule
